FILE: src/rpst_pkg.sv
// ----------------------------------------------------------------------------
// rpst_pkg: shared types for the range progression add / range sum store
// Opcodes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpst_pkg;

    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned SUM_W    = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic load_ok;
        logic empty;
        logic at_end;
    } t_status;

endpackage

FILE: src/rpst_if.sv
// ----------------------------------------------------------------------------
// rpst_req_if / rpst_rsp_if: request and response channels
// Valid/ready channels carrying one request item or one sum item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [9:0]  first_index;
    logic [9:0]  last_index;
    logic signed [31:0] element_value;

    modport source (output valid, opcode, first_index, last_index, element_value,
                    input ready);
    modport sink   (input valid, opcode, first_index, last_index, element_value,
                    output ready);
endinterface

interface rpst_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface

FILE: src/range_progression_add_sum_tree_top.sv
// ----------------------------------------------------------------------------
// range_progression_add_sum_tree_top: progression add / range sum store
// Element store with load, arithmetic progression add and range sum query.
//
//   channel   dir  payload
//   i_req     in   opcode, first_index, last_index, element_value
//   o_rsp     out  range_sum (queries only)
//
// Load, unused opcodes and adds over an empty range finish as they are taken;
// other adds sweep the range, one memory read-modify-write per element, and
// queries sum it, one memory read per element; an empty query goes straight
// to the output. A query result then waits in the output until taken. After
// reset a clearing pass zeroes every element before the first item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_progression_add_sum_tree_top
    import rpst_pkg::*;
#(
    parameter int unsigned ELEMENTS = 1024
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpst_req_if.sink    i_req,
    rpst_rsp_if.source  o_rsp
);

    t_cmd    w_cmd;
    t_status w_status;

    rpst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_opcode    (i_req.opcode),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    rpst_dp #(.ELEMENTS(ELEMENTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (i_req.opcode),
        .i_first_index   (i_req.first_index),
        .i_last_index    (i_req.last_index),
        .i_element_value (i_req.element_value),
        .o_status        (w_status),
        .o_range_sum     (o_rsp.range_sum)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd)) else $error("more than one datapath command");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rsp.valid && i_req.ready)) else $error("item taken while result pending");

    a_step_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !i_req.ready) else $error("item taken during sweep");

endmodule

FILE: src/rpst_ctrl.sv
// ----------------------------------------------------------------------------
// rpst_ctrl: operation sequencer
// Runs the clearing pass, takes items and steps the datapath through a range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpst_ctrl
    import rpst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic                i_rsp_ready,
    input  t_status             i_status,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    output t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WORK,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_is_query, n_is_query;

    always_comb begin
        n_state     = r_state;
        n_is_query  = r_is_query;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    unique case (t_opcode'(i_opcode))
                        OP_LOAD: begin
                            o_cmd.load = i_status.load_ok;
                        end
                        OP_ADD: begin
                            n_is_query = 1'b0;
                            if (!i_status.empty) begin
                                o_cmd.start = 1'b1;
                                n_state     = S_WORK;
                            end
                        end
                        OP_QUERY: begin
                            n_is_query  = 1'b1;
                            o_cmd.start = 1'b1;
                            n_state     = i_status.empty ? S_OUT : S_WORK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WORK: begin
                o_cmd.step = 1'b1;
                if (i_status.at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_is_query ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_is_query <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_query <= n_is_query;
        end
    end

endmodule

FILE: src/rpst_dp.sv
// ----------------------------------------------------------------------------
// rpst_dp: element store and range datapath
// Element memory with a read-modify-write sweep for adds and an accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpst_dp
    import rpst_pkg::*;
#(
    parameter int unsigned ELEMENTS = 1024
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_first_index,
    input  logic [INDEX_W-1:0]  i_last_index,
    input  logic [VALUE_W-1:0]  i_element_value,
    output t_status             o_status,
    output logic [SUM_W-1:0]    o_range_sum
);

    localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    logic [SUM_W-1:0] r_mem [ELEMENTS];
    logic [SUM_W-1:0] r_q;
    logic [AW-1:0]    r_ptr, r_end, r_rd_addr;
    logic             r_rd_vld, r_is_add;
    logic [AW:0]      r_inc;
    logic [SUM_W-1:0] r_acc;

    logic [31:0]      w_first, w_last, w_last_clip;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [SUM_W-1:0] w_wr_data;

    assign w_first     = {{(32-INDEX_W){1'b0}}, i_first_index};
    assign w_last      = {{(32-INDEX_W){1'b0}}, i_last_index};
    assign w_last_clip = (w_last >= 32'(ELEMENTS)) ? 32'(ELEMENTS - 1) : w_last;

    assign o_status.load_ok    = w_first < 32'(ELEMENTS);
    assign o_status.empty      = (w_first >= 32'(ELEMENTS)) || (w_first > w_last_clip);
    assign o_status.clear_done = r_ptr == AW'(ELEMENTS - 1);
    assign o_status.at_end     = r_ptr == r_end;
    assign o_range_sum         = r_acc;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_ptr;
        w_wr_data = '0;
        priority if (i_cmd.clear) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.load) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_first[AW-1:0];
            w_wr_data = {{(SUM_W-VALUE_W){i_element_value[VALUE_W-1]}}, i_element_value};
        end else if (r_rd_vld && r_is_add) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_rd_addr;
            w_wr_data = r_q + {{(SUM_W-AW-1){1'b0}}, r_inc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_q <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (i_cmd.clear || i_cmd.step) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (i_cmd.start) begin
                r_ptr <= w_first[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_end    <= w_last_clip[AW-1:0];
            r_is_add <= t_opcode'(i_opcode) == OP_ADD;
            r_inc    <= (AW+1)'(1);
            r_acc    <= '0;
        end else if (r_rd_vld) begin
            if (r_is_add) begin
                r_inc <= r_inc + 1'b1;
            end else begin
                r_acc <= r_acc + r_q;
            end
        end
        if (i_cmd.step) begin
            r_rd_addr <= r_ptr;
        end
    end

endmodule
